// ===== rtl/mtt_pkg.sv =====
// Package for the markup tag tokenizer: codes, characters and the result record.
`default_nettype none

package mtt_pkg;

  // Default width of the attribute and token counters.
  localparam int COUNT_BITS_DEF = 8;

  // Width of the reported attribute index and token position.
  localparam int REPORT_BITS = 8;

  // Parser states.
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_NAME  = 3'd1;
  localparam logic [2:0] MODE_GAP   = 3'd2;
  localparam logic [2:0] MODE_ATTR  = 3'd3;
  localparam logic [2:0] MODE_WAIT  = 3'd4;
  localparam logic [2:0] MODE_VALUE = 3'd5;

  // Kind codes of a classified byte.
  localparam logic [3:0] KIND_SKIP       = 4'd0;
  localparam logic [3:0] KIND_END_MARK   = 4'd1;
  localparam logic [3:0] KIND_NAME_CHAR  = 4'd2;
  localparam logic [3:0] KIND_NAME_DONE  = 4'd3;
  localparam logic [3:0] KIND_ATTR_CHAR  = 4'd4;
  localparam logic [3:0] KIND_EQUALS     = 4'd5;
  localparam logic [3:0] KIND_OPEN_QUOTE = 4'd6;
  localparam logic [3:0] KIND_VALUE_CHAR = 4'd7;
  localparam logic [3:0] KIND_ATTR_DONE  = 4'd8;
  localparam logic [3:0] KIND_TAG_DONE   = 4'd9;

  // Characters with a meaning in a tag.
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // One classified byte as it leaves the block.
  typedef struct packed {
    logic [2:0]             mode_after;
    logic [REPORT_BITS-1:0] token_pos;
    logic [REPORT_BITS-1:0] attr_index;
    logic                   closing_tag;
    logic [7:0]             char_out;
    logic [3:0]             kind;
  } result_t;

  // Letters, digits and the underscore form names.
  function automatic logic is_name_char(input logic [7:0] c);
    is_name_char = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/markup_tag_tokenizer_core.sv =====
// Top level of the markup tag tokenizer: input register, parser state and result register.
//
//   Channel | Direction | tdata (low bit up)                                   | tuser
//   s_*     | in        | char_in[7:0]                                         | restart
//   m_*     | out       | char_out[7:0], closing_tag, attr_index[7:0],         | kind[3:0]
//           |           | token_pos[7:0], mode_after[2:0], zero pad to 32 bits |
//
// One byte is taken per clock unless m_* stalls; its result is valid on m_* once it is in the result register.
// The parser state is updated as a byte moves from the input register into the result
// register, so the path through the transition logic sets the clock.
// rst clears the parser state and both valid flags; payload registers are not reset.
// While the result waits, the input register still takes one more byte.
`default_nettype none

module markup_tag_tokenizer_core
  import mtt_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // char_in[7:0]
  input  wire logic        s_tuser,   // restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // char_out, closing_tag, attr_index, token_pos, mode_after
  output logic [3:0]       m_tuser    // kind
);

  logic                  in_valid;
  logic [7:0]            in_char;
  logic                  in_restart;
  logic                  advance;
  logic [2:0]            mode;
  logic                  end_flag;
  logic [COUNT_BITS-1:0] attr_cnt;
  logic [COUNT_BITS-1:0] tok_cnt;
  logic [2:0]            mode_next;
  logic                  end_flag_next;
  logic [COUNT_BITS-1:0] attr_cnt_next;
  logic [COUNT_BITS-1:0] tok_cnt_next;
  result_t               res_next;
  result_t               res;

  // A held byte moves on whenever the result register is free or being emptied.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char    <= s_tdata;
      in_restart <= s_tuser;
    end
  end

  // Classification of the held byte.
  mtt_classify #(
    .COUNT_BITS(COUNT_BITS)
  ) u_classify (
    .char_in       (in_char),
    .restart       (in_restart),
    .mode          (mode),
    .end_flag      (end_flag),
    .attr_cnt      (attr_cnt),
    .tok_cnt       (tok_cnt),
    .res           (res_next),
    .mode_next     (mode_next),
    .end_flag_next (end_flag_next),
    .attr_cnt_next (attr_cnt_next),
    .tok_cnt_next  (tok_cnt_next)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_START;
      end_flag <= 1'b0;
      attr_cnt <= '0;
      tok_cnt  <= '0;
    end else if (advance) begin
      mode     <= mode_next;
      end_flag <= end_flag_next;
      attr_cnt <= attr_cnt_next;
      tok_cnt  <= tok_cnt_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  // Output packing.
  assign m_tuser = res.kind;
  assign m_tdata = {4'b0, res.mode_after, res.token_pos, res.attr_index,
                    res.closing_tag, res.char_out};

endmodule

`default_nettype wire

// ===== rtl/mtt_classify.sv =====
// Next-state and result logic of the tag parser for one byte.
`default_nettype none

module mtt_classify
  import mtt_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic [7:0]            char_in,
  input  wire logic                  restart,
  input  wire logic [2:0]            mode,
  input  wire logic                  end_flag,
  input  wire logic [COUNT_BITS-1:0] attr_cnt,
  input  wire logic [COUNT_BITS-1:0] tok_cnt,
  output result_t                    res,
  output logic [2:0]                 mode_next,
  output logic                       end_flag_next,
  output logic [COUNT_BITS-1:0]      attr_cnt_next,
  output logic [COUNT_BITS-1:0]      tok_cnt_next
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam int WIDE_BITS = COUNT_BITS + REPORT_BITS;
  localparam logic [WIDE_BITS-1:0] REPORT_MAX = WIDE_BITS'((1 << REPORT_BITS) - 1);

  logic [2:0]            mode_cur;
  logic                  flag_cur;
  logic [COUNT_BITS-1:0] attr_cur;
  logic [COUNT_BITS-1:0] tok_cur;
  logic [COUNT_BITS-1:0] tok_inc;
  logic [COUNT_BITS-1:0] attr_inc;
  logic [3:0]            kind;
  logic [COUNT_BITS-1:0] pos;
  logic                  done;
  logic [2:0]            mode_upd;
  logic                  flag_upd;
  logic [COUNT_BITS-1:0] attr_upd;
  logic [COUNT_BITS-1:0] tok_upd;

  // Clip a counter value to the reported width.
  function automatic logic [REPORT_BITS-1:0] clip(input logic [COUNT_BITS-1:0] v);
    logic [WIDE_BITS-1:0] w;
    w = {{REPORT_BITS{1'b0}}, v};
    clip = (w > REPORT_MAX) ? REPORT_MAX[REPORT_BITS-1:0] : w[REPORT_BITS-1:0];
  endfunction

  // A restart clears the state before the byte is looked at.
  assign mode_cur = restart ? MODE_START : mode;
  assign flag_cur = restart ? 1'b0 : end_flag;
  assign attr_cur = restart ? '0 : attr_cnt;
  assign tok_cur  = restart ? '0 : tok_cnt;
  assign tok_inc  = (tok_cur == CNT_MAX) ? CNT_MAX : tok_cur + CNT_ONE;
  assign attr_inc = (attr_cur == CNT_MAX) ? CNT_MAX : attr_cur + CNT_ONE;

  // Transition table of the parser.
  always_comb begin
    kind     = KIND_SKIP;
    pos      = '0;
    done     = 1'b0;
    mode_upd = mode_cur;
    flag_upd = flag_cur;
    attr_upd = attr_cur;
    tok_upd  = tok_cur;
    case (mode_cur)
      MODE_NAME: begin
        if (char_in == CH_GT) begin
          kind = KIND_TAG_DONE;
          done = 1'b1;
        end else if (is_name_char(char_in)) begin
          kind    = KIND_NAME_CHAR;
          pos     = tok_cur;
          tok_upd = tok_inc;
        end else begin
          kind     = KIND_NAME_DONE;
          mode_upd = MODE_GAP;
        end
      end
      MODE_GAP: begin
        if (char_in == CH_GT) begin
          kind = KIND_TAG_DONE;
          done = 1'b1;
        end else if (is_name_char(char_in)) begin
          kind     = KIND_ATTR_CHAR;
          tok_upd  = CNT_ONE;
          mode_upd = MODE_ATTR;
        end
      end
      MODE_ATTR: begin
        if (char_in == CH_EQ) begin
          kind     = KIND_EQUALS;
          mode_upd = MODE_WAIT;
        end else begin
          kind    = KIND_ATTR_CHAR;
          pos     = tok_cur;
          tok_upd = tok_inc;
        end
      end
      MODE_WAIT: begin
        if (char_in == CH_QUOTE) begin
          kind     = KIND_OPEN_QUOTE;
          tok_upd  = '0;
          mode_upd = MODE_VALUE;
        end
      end
      MODE_VALUE: begin
        if (char_in == CH_QUOTE) begin
          kind     = KIND_ATTR_DONE;
          attr_upd = attr_inc;
          mode_upd = MODE_GAP;
        end else begin
          kind    = KIND_VALUE_CHAR;
          pos     = tok_cur;
          tok_upd = tok_inc;
        end
      end
      default: begin
        if (char_in == CH_SLASH) begin
          kind     = KIND_END_MARK;
          flag_upd = 1'b1;
          mode_upd = MODE_START;
        end else begin
          kind     = KIND_NAME_CHAR;
          tok_upd  = CNT_ONE;
          mode_upd = MODE_NAME;
        end
      end
    endcase
  end

  // The end of a tag clears the state; closing_tag and attr_index still show it, mode_after shows MODE_START.
  assign mode_next     = done ? MODE_START : mode_upd;
  assign end_flag_next = done ? 1'b0 : flag_upd;
  assign attr_cnt_next = done ? '0 : attr_upd;
  assign tok_cnt_next  = done ? '0 : tok_upd;

  // Assemble the result item.
  assign res.kind        = kind;
  assign res.char_out    = char_in;
  assign res.closing_tag = flag_upd;
  assign res.attr_index  = clip(attr_upd);
  assign res.token_pos   = clip(pos);
  assign res.mode_after  = mode_next;

endmodule

`default_nettype wire
